@@ rtl/core/running_lower_median_core_macros.svh @@
// ============================================================================
// Assertion macros for the running lower median core
// Shorthand for the concurrent checks in the core's controller, rlm_ctrl.
// ============================================================================
`ifndef RUNNING_LOWER_MEDIAN_CORE_MACROS_SVH
`define RUNNING_LOWER_MEDIAN_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RLM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/rlm_pkg.sv @@
// ============================================================================
// rlm_pkg
// Types and constants shared by the running lower median core.
// ============================================================================
`default_nettype none

package rlm_pkg;

    // Field widths of the stream payloads.
    localparam int SAMPLE_W  = 16;
    localparam int COUNT_W   = 11;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 32;

    // Configuration register map.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd1;

    // Bound values after reset.
    localparam logic signed [SAMPLE_W-1:0] LOWER_BOUND_RESET = -16'sd10000;
    localparam logic signed [SAMPLE_W-1:0] UPPER_BOUND_RESET = 16'sd10000;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_HALTED  = 2'd3
    } rlm_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        load_sample;  // latch the request's sample, pos := count
        logic        rd_prev;      // read the entry below the insertion point
        logic        wr_shift;     // move the entry read up one place, pos--
        logic        wr_sample;    // write the sample at pos, count++
        logic        rd_med;       // read the lower median entry
        logic        load_out;     // load the result register
        rlm_status_t status;       // status of the result being loaded
    } rlm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_range;    // latched sample lies within the bounds
        logic full;        // store holds DEPTH samples
        logic count_zero;  // store is empty
        logic gt;          // entry just read is greater than the sample
        logic pos_one;     // insertion point is at index one
    } rlm_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/running_lower_median_core.sv @@
// Requests are taken one at a time: a new request is accepted only after the
// previous result has been loaded. An inserted sample first moves each held entry
// greater than it up one place; the entry shift moves one store entry per cycle
// through the RAM's single write port.
// Reset: synchronous, active low; empties the store, clears the halt and
// restores the bounds to -10000 and 10000. The store RAM itself is not cleared.
// ============================================================================
// running_lower_median_core
// Running lower median by sorted insertion, with range check and halt.
// ============================================================================
`default_nettype none

module running_lower_median_core #(
    parameter int DEPTH = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Configuration write channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rlm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rlm_pkg::SAMPLE_W-1:0]       cfg_data,
    // Sample stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [rlm_pkg::S_TDATA_W-1:0]      s_tdata,   // [15:0] sample
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [rlm_pkg::M_TDATA_W-1:0]           m_tdata,   // [15:0] median,
                                                               // [26:16] sample_count
    output logic [rlm_pkg::STATUS_W-1:0]            m_tuser    // [1:0] status
);

    import rlm_pkg::*;

    rlm_cmd_t             cmd;
    rlm_sts_t             sts;
    logic [SAMPLE_W-1:0]  median;
    logic [COUNT_W-1:0]   sample_count;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    rlm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rlm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (s_tdata[SAMPLE_W-1:0]),
        .cmd          (cmd),
        .sts          (sts),
        .median       (median),
        .sample_count (sample_count),
        .status       (m_tuser)
    );

    // Pack the result fields, median in the low bits.
    assign m_tdata = {{(M_TDATA_W - SAMPLE_W - COUNT_W){1'b0}}, sample_count, median};

endmodule

`default_nettype wire

@@ rtl/core/rlm_ram.sv @@
// ============================================================================
// rlm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
`default_nettype none

module rlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/rlm_dp.sv @@
// ============================================================================
// rlm_dp
// Datapath: bound registers, sorted store, insertion pointer, count and
// result register.
// ============================================================================
`default_nettype none

module rlm_dp #(
    parameter int DEPTH = 1024
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_valid,
    input  wire logic [rlm_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [rlm_pkg::SAMPLE_W-1:0]          cfg_data,
    input  wire logic [rlm_pkg::SAMPLE_W-1:0]          sample,
    input  wire rlm_pkg::rlm_cmd_t                     cmd,
    output rlm_pkg::rlm_sts_t                          sts,
    output logic [rlm_pkg::SAMPLE_W-1:0]               median,
    output logic [rlm_pkg::COUNT_W-1:0]                sample_count,
    output logic [rlm_pkg::STATUS_W-1:0]               status
);

    import rlm_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [SAMPLE_W-1:0] lower_reg;
    logic signed [SAMPLE_W-1:0] upper_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [AW-1:0]              pos_reg;
    logic [CW-1:0]              count_reg;
    logic [SAMPLE_W-1:0]        median_reg;
    logic [COUNT_W-1:0]         count_out_reg;
    logic [STATUS_W-1:0]        status_reg;

    logic                       ram_wr_en;
    logic [AW-1:0]              ram_rd_addr;
    logic [SAMPLE_W-1:0]        ram_wr_data;
    logic [SAMPLE_W-1:0]        ram_rd_data;
    logic [AW-1:0]              med_idx;
    logic [CW-1:0]              count_dec;

    // Configuration registers; writes to unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= LOWER_BOUND_RESET;
            upper_reg <= UPPER_BOUND_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_LOWER_BOUND) begin
                lower_reg <= cfg_data;
            end
            if (cfg_index == CFG_UPPER_BOUND) begin
                upper_reg <= cfg_data;
            end
        end
    end

    // Held count and insertion pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
        end else begin
            if (cmd.load_sample) begin
                pos_reg <= AW'(count_reg);
            end else if (cmd.wr_shift) begin
                pos_reg <= pos_reg - AW'(1);
            end
            if (cmd.wr_sample) begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Sample and result payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= sample;
        end
        if (cmd.load_out) begin
            median_reg    <= sts.count_zero ? '0 : ram_rd_data;
            count_out_reg <= COUNT_W'(count_reg);
            status_reg    <= cmd.status;
        end
    end

    // Store addressing. While shifting, the next read is two below pos.
    assign count_dec   = count_reg - CW'(1);
    assign med_idx     = AW'(count_dec >> 1);
    assign ram_wr_en   = cmd.wr_shift | cmd.wr_sample;
    assign ram_wr_data = cmd.wr_shift ? ram_rd_data : sample_reg;

    always_comb begin
        if (cmd.rd_med) begin
            ram_rd_addr = med_idx;
        end else if (cmd.wr_shift) begin
            ram_rd_addr = pos_reg - AW'(2);
        end else begin
            ram_rd_addr = pos_reg - AW'(1);
        end
    end

    rlm_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.rd_prev | cmd.rd_med),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Status toward the controller.
    assign sts.in_range   = (sample_reg >= lower_reg) && (sample_reg <= upper_reg);
    assign sts.full       = (count_reg == CW'(DEPTH));
    assign sts.count_zero = (count_reg == '0);
    assign sts.gt         = ($signed(ram_rd_data) > sample_reg);
    assign sts.pos_one    = (pos_reg == AW'(1));

    assign median       = median_reg;
    assign sample_count = count_out_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

@@ rtl/core/rlm_ctrl.sv @@
// ============================================================================
// rlm_ctrl
// Controller: sequences range check, sorted insertion and median read-out.
// ============================================================================
`default_nettype none
`include "running_lower_median_core_macros.svh"

module rlm_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire rlm_pkg::rlm_sts_t sts,
    output rlm_pkg::rlm_cmd_t      cmd
);

    import rlm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SHIFT,
        S_PLACE,
        S_MED,
        S_MEDW
    } state_t;

    state_t      state_reg,  state_next;
    logic        halted_reg, halted_next;
    logic        valid_reg,  valid_next;
    rlm_status_t status_reg, status_next;

    // Next state, commands and registered outputs.
    always_comb begin
        state_next  = state_reg;
        halted_next = halted_reg;
        valid_next  = valid_reg & ~m_tready;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_sample = 1'b1;
                    state_next      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (halted_reg) begin
                    status_next = ST_HALTED;
                    state_next  = S_MED;
                end else if (!sts.in_range) begin
                    halted_next = 1'b1;
                    status_next = ST_RANGE;
                    state_next  = S_MED;
                end else if (sts.full) begin
                    status_next = ST_FULL;
                    state_next  = S_MED;
                end else if (sts.count_zero) begin
                    status_next = ST_OK;
                    state_next  = S_PLACE;
                end else begin
                    status_next = ST_OK;
                    cmd.rd_prev = 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // Entry below the insertion point is in the read register.
                if (sts.gt) begin
                    cmd.wr_shift = 1'b1;
                    if (sts.pos_one) begin
                        state_next = S_PLACE;
                    end else begin
                        cmd.rd_prev = 1'b1;
                    end
                end else begin
                    cmd.wr_sample = 1'b1;
                    state_next    = S_MED;
                end
            end
            S_PLACE: begin
                cmd.wr_sample = 1'b1;
                state_next    = S_MED;
            end
            S_MED: begin
                cmd.rd_med = 1'b1;
                state_next = S_MEDW;
            end
            S_MEDW: begin
                if (!valid_reg || m_tready) begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            halted_reg <= 1'b0;
            valid_reg  <= 1'b0;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            halted_reg <= halted_next;
            valid_reg  <= valid_next;
            status_reg <= status_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = valid_reg;

    // Once halted, the block stays halted until reset.
    `RLM_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halted_reg, halted_reg,
        "halted flag cleared without reset")

    // Insertion never runs against a full store.
    `RLM_ASSERT_IMP(a_no_insert_full, aclk, aresetn,
        state_reg == S_SHIFT || state_reg == S_PLACE, !sts.full,
        "insertion started with a full store")

    // A new result never overwrites one that has not been taken.
    `RLM_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.load_out,
        !valid_reg || m_tready, "result register overwritten")

    // An accepted request always goes to the range check.
    `RLM_ASSERT_NEXT(a_accept_check, aclk, aresetn, s_tvalid && s_tready,
        state_reg == S_CHECK, "accepted request skipped the range check")

endmodule

`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Running lower median core testbench
// Sends signed samples under several bound settings and checks every result.
// Each result's median, count and status are compared with a sorted-store
// predictor that is updated as each request is accepted. The sequence covers
// bounds at their edges, equal samples and back-pressure. It ends with a
// crossed-bounds halt, because only a reset clears the halt.
// ============================================================================

module tb;
    import rlm_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int LIMIT_CYCLES = 6_000_000;

    // Expected content of one result.
    typedef struct {
        logic signed [SAMPLE_W-1:0] median;
        logic [COUNT_W-1:0]         count;
        rlm_status_t                status;
    } median_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOWER_BOUND;
    logic [SAMPLE_W-1:0]   cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [15:0] sample
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [15:0] median, [26:16] sample_count
    logic [STATUS_W-1:0]   m_tuser;          // [1:0] status

    // Predictor state: sorted copy of the store, halt flag and bounds.
    logic signed [SAMPLE_W-1:0] sorted_samples[$];
    logic                       store_halted = 1'b0;
    logic signed [SAMPLE_W-1:0] lo_bound     = LOWER_BOUND_RESET;
    logic signed [SAMPLE_W-1:0] hi_bound     = UPPER_BOUND_RESET;
    logic signed [SAMPLE_W-1:0] last_sample  = '0;

    median_result_t pending_results[$];
    int             error_count     = 0;
    int             send_idle_pct   = 0;
    int             recv_idle_pct   = 0;
    int             hold_off_cycles = 0;
    int             cycle_count     = 0;

    running_lower_median_core #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Inserts an accepted sample into the sorted copy and returns the result it causes.
    function automatic median_result_t predict_median(input logic signed [SAMPLE_W-1:0] s);
        median_result_t r;
        int pos;
        if (store_halted) begin
            r.status = ST_HALTED;
        end else if (s < lo_bound || s > hi_bound) begin
            store_halted = 1'b1;
            r.status = ST_RANGE;
        end else if (sorted_samples.size() >= DEPTH) begin
            r.status = ST_FULL;
        end else begin
            // Equal samples go after the ones already held.
            pos = sorted_samples.size();
            while (pos > 0 && sorted_samples[pos-1] > s) pos--;
            sorted_samples.insert(pos, s);
            r.status = ST_OK;
        end
        r.count  = COUNT_W'(sorted_samples.size());
        r.median = (sorted_samples.size() == 0) ? '0
                                                : sorted_samples[(sorted_samples.size()-1)/2];
        return r;
    endfunction

    // Offers one sample request, with random idle cycles ahead of it.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_median(s));
        last_sample = s;
    endtask

    // Stops offering requests and waits until every expected result has come.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Writes both bound registers back to back while the block is idle.
    task automatic write_bounds(input logic signed [SAMPLE_W-1:0] lo,
                                input logic signed [SAMPLE_W-1:0] hi);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_LOWER_BOUND;
        cfg_data  <= lo;
        do @(posedge aclk); while (!cfg_ready);
        lo_bound = lo;
        cfg_index <= CFG_UPPER_BOUND;
        cfg_data  <= hi;
        do @(posedge aclk); while (!cfg_ready);
        hi_bound = hi;
        cfg_valid <= 1'b0;
    endtask

    // Draws a sample inside the current bounds, weighted toward edges and repeats.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        int span;
        int roll;
        span = int'(hi_bound) - int'(lo_bound);
        roll = $urandom_range(99, 0);
        if (roll < 8) return lo_bound;
        if (roll < 16) return hi_bound;
        if (roll < 30 && last_sample >= lo_bound && last_sample <= hi_bound)
            return last_sample;
        return SAMPLE_W'(int'(lo_bound) + int'($urandom_range(span, 0)));
    endfunction

    // Bounds after reset, samples on both bounds and equal samples.
    task automatic test_reset_bounds();
        send_sample(16'sd10000);
        send_sample(-16'sd10000);
        send_sample(16'sd0);
        send_sample(16'sd0);
        send_sample(16'sd9999);
        send_sample(-16'sd10000);
    endtask

    // Widest bounds with samples at the extremes and alternating bit patterns.
    task automatic test_bound_extremes();
        write_bounds(16'sh8000, 16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh7fff);
        send_sample(16'sh5555);
        send_sample(16'shaaaa);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd0);
        send_sample(16'sh7ffe);
    endtask

    // A one-value window: only that value is accepted.
    task automatic test_equal_bounds();
        write_bounds(16'sd7, 16'sd7);
        repeat (3) send_sample(16'sd7);
    endtask

    // Random in-range samples in three phases with different bounds and idling.
    task automatic test_random_stream();
        logic signed [SAMPLE_W-1:0] a;
        logic signed [SAMPLE_W-1:0] b;
        write_bounds(16'sh8000, 16'sh7fff);
        send_idle_pct = 15;
        recv_idle_pct = 77;
        repeat (200) send_sample(pick_sample());

        a = SAMPLE_W'($urandom);
        b = SAMPLE_W'($urandom);
        if (a <= b) write_bounds(a, b);
        else write_bounds(b, a);
        send_idle_pct = 77;
        recv_idle_pct = 15;
        repeat (200) send_sample(pick_sample());

        // A narrow window gives many equal samples.
        write_bounds(-16'sd50, 16'sd50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (130) send_sample(pick_sample());
    endtask

    // Receiver holds off while requests keep coming; then the sender drains.
    task automatic test_backpressure();
        write_bounds(16'sh8000, 16'sh7fff);
        hold_off_cycles = 400;
        repeat (16) send_sample(SAMPLE_W'(32000 + $urandom_range(767, 0)));
        wait_for_results();
        repeat (8) send_sample(pick_sample());
    endtask

    // Crossed bounds reject the first sample; everything after reports halted.
    task automatic test_halt();
        write_bounds(16'sh7fff, 16'sh8000);
        send_sample(16'sd0);
        send_sample(16'sh7fff);
        send_sample(16'sh8000);
        send_sample(16'sh1234);
        write_bounds(16'sh8000, 16'sh7fff);
        send_sample(16'sd5);
        send_sample(-16'sd5);
    endtask

    // Result checker and receiver ready, with a counted hold-off.
    always @(posedge aclk) begin : result_check
        median_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %0d",
                       m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if ($signed(m_tdata[15:0]) != want.median) begin
                    $error("median: expected %0d, got %0d", want.median,
                           $signed(m_tdata[15:0]));
                    error_count++;
                end
                if (m_tdata[26:16] != want.count) begin
                    $error("sample_count: expected %0d, got %0d", want.count,
                           m_tdata[26:16]);
                    error_count++;
                end
                if (m_tuser != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[31:27] != '0) begin
                    $error("tdata padding: expected 0, got %0d", m_tdata[31:27]);
                    error_count++;
                end
            end
        end
        if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles--;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Watchdog on the total run length.
    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        send_idle_pct = 15;
        recv_idle_pct = 77;
        test_reset_bounds();
        test_bound_extremes();
        test_equal_bounds();
        test_random_stream();
        test_backpressure();
        test_halt();

        // Let any stray result show up before the verdict.
        wait_for_results();
        repeat (DEPTH + 16) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
